### hdl/tct_pkg.sv
`default_nettype none
package tct_pkg;

  typedef enum logic [2:0] {
    REQ_ACQUIRE = 3'd0,
    REQ_START   = 3'd1,
    REQ_END     = 3'd2,
    REQ_DISCARD = 3'd3,
    REQ_QUERY   = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TS_INVALID   = 2'd0,
    TS_PENDING   = 2'd1,
    TS_RUNNING   = 2'd2,
    TS_COMPLETED = 2'd3
  } tstate_t;

  localparam int unsigned GEN_W   = 32;
  localparam int unsigned COUNT_W = 16;

  // One input item.
  typedef struct packed {
    logic [2:0]         req_type;
    logic [COUNT_W-1:0] job_count;
    logic               lane_sel;
    logic [7:0]         slot_index;
    logic [GEN_W-1:0]   query_generation;
    logic               ticket_null;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [5:0]       out_slot;
    logic [GEN_W-1:0] out_generation;
    logic [1:0]       ticket_state;
    logic             slot_freed;
    logic             out_lane;
  } rsp_t;

  // Per-slot record held in the slot RAM.
  typedef struct packed {
    logic [GEN_W-1:0]   generation;
    logic [COUNT_W-1:0] remaining;
    logic [COUNT_W-1:0] running;
    logic               lane;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_STACK = 2'd1,
    S_EXEC  = 2'd2,
    S_OUT   = 2'd3
  } fsm_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic slot_rd;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

### hdl/tct_if.sv
`default_nettype none
interface tct_req_if;
  logic          valid;
  logic          ready;
  tct_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tct_rsp_if;
  logic          valid;
  logic          ready;
  tct_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/ticket_completion_tracker_unit.sv
`default_nettype none
// Channel  Dir  Carries
// -------  ---  ------------------------------------------------------------
// req      in   request item: type, job count, lane, slot, generation, null
// rsp      out  result item: status, slot, generation, state, freed, lane
//
// One item at a time: accept, stack read, slot read, execute, result held.
// Accept cycle overlaps the previous result being taken, so the sustained
// rate is set by the two chained registered RAM reads (free stack, then
// slot record) and the write-back.
// Reset (synchronous rst) empties the handshake and marks every stack and
// slot entry unwritten; unwritten entries read as their reset value.
// A stalled result holds rsp and blocks the next item until it is taken.
module ticket_completion_tracker_unit #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  tct_req_if.sink    req,
  tct_rsp_if.source  rsp
);
  import tct_pkg::*;

  cmd_t cmd;

  // Sequencer: owns both handshakes and steps the datapath.
  tct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Free-slot stack, slot records and the result register.
  tct_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_data (req.payload),
    .rsp_data (rsp.payload)
  );

endmodule
`default_nettype wire

### hdl/tct_ram.sv
`default_nettype none
module tct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hdl/tct_ctrl.sv
`default_nettype none
module tct_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tct_pkg::cmd_t      cmd
);
  import tct_pkg::*;

  fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    req_ready   = 1'b0;
    rsp_valid   = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_STACK;
        end
      end
      S_STACK: begin
        cmd.slot_rd = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        req_ready = rsp_ready;
        if (rsp_ready) begin
          if (req_valid) begin
            cmd.capture = 1'b1;
            state_next  = S_STACK;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/tct_dp.sv
`default_nettype none
module tct_dp #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tct_pkg::cmd_t cmd,
  input  wire tct_pkg::req_t req_data,
  output tct_pkg::rsp_t      rsp_data
);
  import tct_pkg::*;

  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned REC_W  = $bits(slot_t);
  localparam logic [8:0]       IDX_LIMIT = 9'(NUM_SLOTS);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] TOP_IDX  = SLOT_W'(NUM_SLOTS - 1);

  req_t                r;
  logic [CNT_W-1:0]    stk_cnt, stk_cnt_next;
  logic [NUM_SLOTS-1:0] stk_vld;
  logic [NUM_SLOTS-1:0] slot_vld;
  logic                stk_rd_vld;
  logic [SLOT_W-1:0]   stk_def;
  logic                slot_rd_vld;
  logic [SLOT_W-1:0]   idx, idx_next;

  logic [CNT_W-1:0]    cnt_dec;
  logic [SLOT_W-1:0]   stk_raddr;
  logic [SLOT_W-1:0]   stk_rdata;
  logic [SLOT_W-1:0]   stk_waddr;
  logic                push;
  logic [REC_W-1:0]    slot_rdata;
  slot_t               cur, upd;
  logic                slot_we;
  logic                bad_idx;
  rsp_t                rsp_next;

  assign cnt_dec   = stk_cnt - CNT_W'(1);
  assign stk_raddr = cnt_dec[SLOT_W-1:0];

  // Stack entry i resets to NUM_SLOTS-1-i until first written.
  assign idx_next = (r.req_type == REQ_ACQUIRE) ?
                    (stk_rd_vld ? stk_rdata : stk_def) : r.slot_index[SLOT_W-1:0];

  assign cur     = slot_rd_vld ? slot_t'(slot_rdata) : '0;
  assign bad_idx = ({1'b0, r.slot_index} >= IDX_LIMIT);

  tct_ram #(.WIDTH(SLOT_W), .DEPTH(NUM_SLOTS)) u_stack (
    .clk   (clk),
    .we    (cmd.exec && push),
    .waddr (stk_waddr),
    .wdata (idx),
    .re    (cmd.capture),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  tct_ram #(.WIDTH(REC_W), .DEPTH(NUM_SLOTS)) u_slots (
    .clk   (clk),
    .we    (cmd.exec && slot_we),
    .waddr (idx),
    .wdata (upd),
    .re    (cmd.slot_rd),
    .raddr (idx_next),
    .rdata (slot_rdata)
  );

  always_comb begin
    upd          = cur;
    slot_we      = 1'b0;
    push         = 1'b0;
    stk_waddr    = stk_cnt[SLOT_W-1:0];
    stk_cnt_next = stk_cnt;
    rsp_next     = '0;
    case (r.req_type)
      REQ_ACQUIRE: begin
        if (stk_cnt == '0) begin
          rsp_next.status = ST_NO_FREE;
        end else begin
          upd.generation  = cur.generation + GEN_W'(1);
          upd.remaining   = r.job_count;
          upd.running     = '0;
          upd.lane        = r.lane_sel;
          slot_we         = 1'b1;
          rsp_next.out_slot       = 6'(idx);
          rsp_next.out_generation = upd.generation;
          stk_waddr = stk_raddr;
          if (r.job_count == '0) begin
            // zero jobs: slot goes straight back on top
            push                = 1'b1;
            rsp_next.slot_freed = 1'b1;
          end else begin
            stk_cnt_next = cnt_dec;
          end
        end
      end
      REQ_START: begin
        if (bad_idx) begin
          rsp_next.status = ST_BAD;
        end else begin
          slot_we = 1'b1;
          if (cur.running != '1) begin
            upd.running = cur.running + COUNT_W'(1);
          end
        end
      end
      REQ_END, REQ_DISCARD: begin
        if (bad_idx) begin
          rsp_next.status = ST_BAD;
        end else begin
          slot_we = 1'b1;
          if (r.req_type == REQ_END && cur.running != '0) begin
            upd.running = cur.running - COUNT_W'(1);
          end
          if (cur.remaining == '0) begin
            rsp_next.status = ST_BAD;
          end else begin
            upd.remaining = cur.remaining - COUNT_W'(1);
            if (cur.remaining == COUNT_W'(1) && stk_cnt < CNT_FULL) begin
              push                = 1'b1;
              stk_cnt_next        = stk_cnt + CNT_W'(1);
              rsp_next.slot_freed = 1'b1;
            end
          end
        end
      end
      REQ_QUERY: begin
        if (r.ticket_null) begin
          rsp_next.ticket_state = TS_INVALID;
        end else if (bad_idx) begin
          rsp_next.status       = ST_BAD;
          rsp_next.ticket_state = TS_INVALID;
        end else begin
          rsp_next.out_lane = cur.lane;
          if (cur.generation != r.query_generation || cur.remaining == '0) begin
            rsp_next.ticket_state = TS_COMPLETED;
          end else if (cur.running != '0) begin
            rsp_next.ticket_state = TS_RUNNING;
          end else begin
            rsp_next.ticket_state = TS_PENDING;
          end
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r           <= req_data;
      stk_rd_vld  <= stk_vld[stk_raddr];
      stk_def     <= TOP_IDX - stk_raddr;
    end
    if (cmd.slot_rd) begin
      idx         <= idx_next;
      slot_rd_vld <= slot_vld[idx_next];
    end
    if (cmd.exec) begin
      rsp_data    <= rsp_next;
    end
  end

  // Control state: stack depth and written-entry flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      stk_cnt  <= CNT_FULL;
      stk_vld  <= '0;
      slot_vld <= '0;
    end else if (cmd.exec) begin
      stk_cnt <= stk_cnt_next;
      if (push) begin
        stk_vld[stk_waddr] <= 1'b1;
      end
      if (slot_we) begin
        slot_vld[idx] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
